// ===== hw/rtl/sm83ld_pkg.sv =====
// Shared types and constants for the SM83 load-group executor.
// Holds the phase encoding, opcode and register codes, and the result word layout.
// No dependencies.
package sm83ld_pkg;

  localparam logic [15:0] START_ADDR_RST = 16'h0100;
  localparam logic [15:0] HIGH_PAGE      = 16'hFF00;

  localparam int unsigned RESULT_W = 75;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [2:0] {
    PH_FETCH,
    PH_IMM8,
    PH_IMM_LO,
    PH_IMM_HI,
    PH_DATA,
    PH_WRITE,
    PH_WRITE_HI
  } phase_e;

  // Register codes as they appear in the opcode fields.
  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_C   = 3'd1;
  localparam logic [2:0] REG_D   = 3'd2;
  localparam logic [2:0] REG_E   = 3'd3;
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam logic [7:0] OP_HALT       = 8'h76;
  localparam logic [7:0] OP_LD_HLM_N   = 8'h36;
  localparam logic [7:0] OP_LDH_N_A    = 8'hE0;
  localparam logic [7:0] OP_LDH_A_N    = 8'hF0;
  localparam logic [7:0] OP_LD_HL_SPE  = 8'hF8;
  localparam logic [7:0] OP_LD_A16_A   = 8'hEA;
  localparam logic [7:0] OP_LD_A_A16   = 8'hFA;
  localparam logic [7:0] OP_LD_A16_SP  = 8'h08;
  localparam logic [7:0] OP_LD_SP_N16  = 8'h31;
  localparam logic [7:0] OP_LD_BCM_A   = 8'h02;
  localparam logic [7:0] OP_LD_DEM_A   = 8'h12;
  localparam logic [7:0] OP_LD_A_BCM   = 8'h0A;
  localparam logic [7:0] OP_LD_A_DEM   = 8'h1A;
  localparam logic [7:0] OP_LDH_CM_A   = 8'hE2;
  localparam logic [7:0] OP_LDH_A_CM   = 8'hF2;
  localparam logic [7:0] OP_LDI_HLM_A  = 8'h22;
  localparam logic [7:0] OP_LDD_HLM_A  = 8'h32;
  localparam logic [7:0] OP_LDI_A_HLM  = 8'h2A;
  localparam logic [7:0] OP_LDD_A_HLM  = 8'h3A;
  localparam logic [7:0] OP_LD_SP_HL   = 8'hF9;

  // Opcode families matched under a mask.
  localparam logic [7:0] MASK_LD_R_N   = 8'hC7;
  localparam logic [7:0] PAT_LD_R_N    = 8'h06;
  localparam logic [7:0] MASK_LD_RR_NN = 8'hCF;
  localparam logic [7:0] PAT_LD_RR_NN  = 8'h01;

  localparam logic [7:0] FLAG_HALF  = 8'h20;
  localparam logic [7:0] FLAG_CARRY = 8'h10;

  typedef struct packed {
    logic [15:0] sp_value;
    logic [15:0] hl_value;
    logic [7:0]  flags_value;
    logic [7:0]  acc_value;
    logic        unknown_opcode;
    logic        instruction_done;
    logic [7:0]  write_byte;
    logic [15:0] access_address;
    logic        access_is_write;
  } result_t;

endpackage

// ===== hw/rtl/sm83ld_in_stage.sv =====
// Input register for the read-byte stream of the SM83 load-group executor.
// Depends on nothing but the clock and reset.
module sm83ld_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/sm83ld_core.sv =====
// Architectural state and combinational step logic of the SM83 load-group executor.
// Uses sm83ld_pkg for the phase encoding, opcodes and the result layout.
module sm83ld_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output sm83ld_pkg::result_t result_o
);
  import sm83ld_pkg::*;

  logic [7:0]  a_q, a_d;
  logic [7:0]  regs_q [6];
  logic [7:0]  regs_d [6];
  logic        half_q, half_d;
  logic        carry_q, carry_d;
  logic [15:0] sp_q, sp_d;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  opcode_q, opcode_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  hi_q, hi_d;

  function automatic logic [7:0] reg_read(input logic [2:0] code, input logic [7:0] a,
                                          input logic [7:0] r0, input logic [7:0] r1,
                                          input logic [7:0] r2, input logic [7:0] r3,
                                          input logic [7:0] r4, input logic [7:0] r5);
    logic [7:0] v;
    case (code)
      REG_B:   v = r0;
      REG_C:   v = r1;
      REG_D:   v = r2;
      REG_E:   v = r3;
      REG_H:   v = r4;
      REG_L:   v = r5;
      REG_A:   v = a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  always_comb begin
    logic [7:0]  op;
    logic [15:0] hl;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] a16;
    logic [15:0] ext;
    logic [15:0] sum;
    logic [15:0] xs;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [7:0]  wval;
    logic        wen;
    logic        fetch;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        unk;

    a_d      = a_q;
    regs_d   = regs_q;
    half_d   = half_q;
    carry_d  = carry_q;
    sp_d     = sp_q;
    pc_d     = pc_q;
    opcode_d = opcode_q;
    phase_d  = phase_q;
    lo_d     = lo_q;
    hi_d     = hi_q;

    op    = opcode_q;
    hl    = {regs_q[REG_H], regs_q[REG_L]};
    bc    = {regs_q[REG_B], regs_q[REG_C]};
    de    = {regs_q[REG_D], regs_q[REG_E]};
    a16   = {byte_i, lo_q};
    ext   = {{8{byte_i[7]}}, byte_i};
    sum   = sp_q + ext;
    xs    = sp_q ^ ext ^ sum;
    dst   = op[5:3];
    src   = op[2:0];
    wval  = byte_i;
    wen   = 1'b0;
    fetch = 1'b0;
    wr    = 1'b0;
    addr  = 16'h0000;
    data  = 8'h00;
    unk   = 1'b0;

    case (phase_q)
      PH_FETCH: begin
        opcode_d = byte_i;
        op       = byte_i;
        dst      = byte_i[5:3];
        src      = byte_i[2:0];
        if (op[7:6] == 2'b01 && op != OP_HALT) begin
          if (dst == REG_MEM) begin
            wr      = 1'b1;
            addr    = hl;
            data    = reg_read(src, a_q, regs_q[0], regs_q[1], regs_q[2], regs_q[3],
                               regs_q[4], regs_q[5]);
            phase_d = PH_WRITE;
          end else if (src == REG_MEM) begin
            addr    = hl;
            phase_d = PH_DATA;
          end else begin
            wen   = 1'b1;
            wval  = reg_read(src, a_q, regs_q[0], regs_q[1], regs_q[2], regs_q[3],
                             regs_q[4], regs_q[5]);
            fetch = 1'b1;
          end
        end else if ((op & MASK_LD_R_N) == PAT_LD_R_N || op == OP_LDH_N_A ||
                     op == OP_LDH_A_N || op == OP_LD_HL_SPE) begin
          addr    = pc_q;
          pc_d    = pc_q + 16'd1;
          phase_d = PH_IMM8;
        end else if ((op & MASK_LD_RR_NN) == PAT_LD_RR_NN || op == OP_LD_A16_A ||
                     op == OP_LD_A_A16 || op == OP_LD_A16_SP) begin
          addr    = pc_q;
          pc_d    = pc_q + 16'd1;
          phase_d = PH_IMM_LO;
        end else if (op == OP_LD_BCM_A || op == OP_LD_DEM_A) begin
          wr      = 1'b1;
          addr    = (op == OP_LD_BCM_A) ? bc : de;
          data    = a_q;
          phase_d = PH_WRITE;
        end else if (op == OP_LD_A_BCM || op == OP_LD_A_DEM) begin
          addr    = (op == OP_LD_A_BCM) ? bc : de;
          phase_d = PH_DATA;
        end else if (op == OP_LDH_CM_A) begin
          wr      = 1'b1;
          addr    = HIGH_PAGE | {8'h00, regs_q[REG_C]};
          data    = a_q;
          phase_d = PH_WRITE;
        end else if (op == OP_LDH_A_CM) begin
          addr    = HIGH_PAGE | {8'h00, regs_q[REG_C]};
          phase_d = PH_DATA;
        end else if (op == OP_LDI_HLM_A || op == OP_LDD_HLM_A) begin
          wr      = 1'b1;
          addr    = hl;
          data    = a_q;
          phase_d = PH_WRITE;
          {regs_d[REG_H], regs_d[REG_L]} = (op == OP_LDI_HLM_A) ? hl + 16'd1 : hl - 16'd1;
        end else if (op == OP_LDI_A_HLM || op == OP_LDD_A_HLM) begin
          addr    = hl;
          phase_d = PH_DATA;
          {regs_d[REG_H], regs_d[REG_L]} = (op == OP_LDI_A_HLM) ? hl + 16'd1 : hl - 16'd1;
        end else if (op == OP_LD_SP_HL) begin
          sp_d  = hl;
          fetch = 1'b1;
        end else begin
          unk   = 1'b1;
          fetch = 1'b1;
        end
      end
      PH_IMM8: begin
        if (op == OP_LD_HLM_N) begin
          wr      = 1'b1;
          addr    = hl;
          data    = byte_i;
          phase_d = PH_WRITE;
        end else if (op == OP_LDH_N_A) begin
          wr      = 1'b1;
          addr    = HIGH_PAGE | {8'h00, byte_i};
          data    = a_q;
          phase_d = PH_WRITE;
        end else if (op == OP_LDH_A_N) begin
          addr    = HIGH_PAGE | {8'h00, byte_i};
          phase_d = PH_DATA;
        end else if (op == OP_LD_HL_SPE) begin
          // Flags come from the carries out of bits 3 and 7 of the low byte.
          half_d  = xs[4];
          carry_d = xs[8];
          {regs_d[REG_H], regs_d[REG_L]} = sum;
          fetch   = 1'b1;
        end else begin
          wen   = 1'b1;
          fetch = 1'b1;
        end
      end
      PH_IMM_LO: begin
        lo_d    = byte_i;
        addr    = pc_q;
        pc_d    = pc_q + 16'd1;
        phase_d = PH_IMM_HI;
      end
      PH_IMM_HI: begin
        hi_d = byte_i;
        if (op == OP_LD_A16_A) begin
          wr      = 1'b1;
          addr    = a16;
          data    = a_q;
          phase_d = PH_WRITE;
        end else if (op == OP_LD_A_A16) begin
          addr    = a16;
          phase_d = PH_DATA;
        end else if (op == OP_LD_A16_SP) begin
          wr      = 1'b1;
          addr    = a16;
          data    = sp_q[7:0];
          phase_d = PH_WRITE_HI;
        end else if (op == OP_LD_SP_N16) begin
          sp_d  = a16;
          fetch = 1'b1;
        end else begin
          case (op[5:4])
            2'd1: begin
              regs_d[REG_D] = byte_i;
              regs_d[REG_E] = lo_q;
            end
            2'd2: begin
              regs_d[REG_H] = byte_i;
              regs_d[REG_L] = lo_q;
            end
            default: begin
              regs_d[REG_B] = byte_i;
              regs_d[REG_C] = lo_q;
            end
          endcase
          fetch = 1'b1;
        end
      end
      PH_DATA: begin
        if (op[7:6] == 2'b01) begin
          wen = 1'b1;
        end else begin
          a_d = byte_i;
        end
        fetch = 1'b1;
      end
      PH_WRITE_HI: begin
        wr      = 1'b1;
        addr    = {hi_q, lo_q} + 16'd1;
        data    = sp_q[15:8];
        phase_d = PH_WRITE;
      end
      default: begin
        fetch = 1'b1;
      end
    endcase

    if (wen) begin
      if (dst == REG_A) begin
        a_d = wval;
      end else if (dst != REG_MEM) begin
        regs_d[dst] = wval;
      end
    end

    if (fetch) begin
      wr      = 1'b0;
      data    = 8'h00;
      addr    = pc_q;
      pc_d    = pc_q + 16'd1;
      phase_d = PH_FETCH;
    end

    result_o.access_is_write  = wr;
    result_o.access_address   = addr;
    result_o.write_byte       = data;
    result_o.instruction_done = fetch;
    result_o.unknown_opcode   = unk;
    result_o.acc_value        = a_d;
    result_o.flags_value      = (half_d ? FLAG_HALF : 8'h00) | (carry_d ? FLAG_CARRY : 8'h00);
    result_o.hl_value         = {regs_d[REG_H], regs_d[REG_L]};
    result_o.sp_value         = sp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= 8'h00;
      regs_q   <= '{default: 8'h00};
      half_q   <= 1'b0;
      carry_q  <= 1'b0;
      sp_q     <= 16'h0000;
      pc_q     <= START_ADDR_RST + 16'd1;
      opcode_q <= 8'h00;
      phase_q  <= PH_FETCH;
      lo_q     <= 8'h00;
      hi_q     <= 8'h00;
    end else if (cfg_we_i) begin
      // A new start address restarts fetching with its read outstanding.
      pc_q    <= cfg_wdata_i + 16'd1;
      phase_q <= PH_FETCH;
    end else if (fire_i) begin
      a_q      <= a_d;
      regs_q   <= regs_d;
      half_q   <= half_d;
      carry_q  <= carry_d;
      sp_q     <= sp_d;
      pc_q     <= pc_d;
      opcode_q <= opcode_d;
      phase_q  <= phase_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
  end

endmodule

// ===== hw/rtl/sm83ld_out_stage.sv =====
// Result register for the bus-access stream of the SM83 load-group executor.
// Uses sm83ld_pkg for the result layout and the output word width.
module sm83ld_out_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  sm83ld_pkg::result_t                  result_i,
  output logic                                 ready_o,
  output logic                                 valid_o,
  input  logic                                 take_i,
  output logic [sm83ld_pkg::M_TDATA_W-1:0]     tdata_o
);
  import sm83ld_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o = valid_q;
  assign tdata_o = {{(M_TDATA_W - RESULT_W){1'b0}}, result_q};

endmodule

// ===== hw/rtl/sm83_load_instruction_executor_unit.sv =====
// Top level of the SM83 load-group executor: input register, step core, result register.
// Uses sm83ld_pkg, sm83ld_in_stage, sm83ld_core and sm83ld_out_stage.

// Each input word is the byte answered by the previous bus access and each output word is
// the next bus access together with the A, F, HL and SP values after that step. After reset
// or a write of the start address, the read of that address counts as issued, so the first
// input word is the first opcode. The block takes one word per clock unless the result
// register is full, and gives one word per input word: an accepted input word waits in the
// input register until it is stepped, which loads its result word into the result register.
// The step logic between the input register and the result register completes an
// instruction phase each cycle that a word is stepped, and the register file updates in
// that same cycle, so consecutive bus cycles never wait on each other. The start address
// may be written only while no word is in flight.
module sm83_load_instruction_executor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // start_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] read_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] access_is_write, [16:1] access_address, [24:17] write_byte,
  // [25] instruction_done, [26] unknown_opcode, [34:27] acc_value,
  // [42:35] flags_value, [58:43] hl_value, [74:59] sp_value, [79:75] zero
  output logic [79:0] m_axis_tdata
);
  import sm83ld_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_ready;
  logic       fire;
  result_t    step_result;

  assign fire = in_valid && out_ready;

  sm83ld_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (fire),
    .byte_o  (in_byte)
  );

  sm83ld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .result_o    (step_result)
  );

  sm83ld_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (step_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .tdata_o  (m_axis_tdata)
  );

  // A stepped word always reaches the result register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> m_axis_tvalid)
    else $error("stepped word did not reach the result register");

  // An opcode fetch is a read with no data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[25]) |-> (!m_axis_tdata[0] && m_axis_tdata[24:17] == 8'h00))
    else $error("opcode fetch carries write data");

  // An unhandled opcode is reported only on the fetch that skips it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[26]) |-> m_axis_tdata[25])
    else $error("unknown opcode flagged outside a fetch");

  // Only the half-carry and carry flag bits are ever set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[42:35] & 8'hCF) == 8'h00))
    else $error("flag register has bits outside half-carry and carry");

endmodule
